@@ hw/rtl/mmacc_pkg.sv @@
`default_nettype none

package mmacc_pkg;

   // number of mouse entries by default
   localparam int MICE_DEFAULT = 16;

   // item operation codes
   localparam logic [2:0] MODE_MOVE_ABS  = 3'd0;
   localparam logic [2:0] MODE_MOVE_KEEP = 3'd1;
   localparam logic [2:0] MODE_BTN_EDIT  = 3'd2;
   localparam logic [2:0] MODE_READ      = 3'd3;
   localparam logic [2:0] MODE_OPEN      = 3'd4;

   // result status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_DATA = 1'b1;

   // limits
   localparam logic signed [13:0] ACC_MAX    = 14'sd2048;
   localparam logic signed [13:0] ACC_MIN    = -14'sd2048;
   localparam logic signed [12:0] REP_MAX    = 13'sd127;
   localparam logic signed [12:0] REP_MIN    = -13'sd127;
   localparam logic [7:0]         HDR_MARK   = 8'h80;
   localparam logic [2:0]         BTN_RESET  = 3'd7;

   // configuration register indexes
   localparam logic REG_INIT_BUTTONS = 1'b0;

   // one stored mouse entry
   typedef struct packed {
      logic signed [12:0] accum_x;
      logic signed [12:0] accum_y;
      logic [2:0]         buttons;
      logic               ready;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{
      accum_x: 13'sd0,
      accum_y: 13'sd0,
      buttons: BTN_RESET,
      ready:   1'b0
   };

endpackage

`default_nettype wire

@@ hw/rtl/mmacc_ram.sv @@
`default_nettype none

module mmacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/mouse_motion_accumulator_top.sv @@
`default_nettype none

// The result strobe is high in the cycle after the execute cycle.
// Items are not overlapped: busy holds off a new item during the entry memory
// read-modify-write (read in the accept cycle, update and write back in the next).
// The receiver cannot stall: rsp_valid is high for exactly one cycle per item.
// Reset (synchronous): all entries read as zero motion, buttons 7, not ready
// (per-entry valid bits cleared at once), init_buttons returns to 7.
module mouse_motion_accumulator_top
   import mmacc_pkg::*;
#(
   parameter int MICE = MICE_DEFAULT,
   localparam int AW = (MICE > 1) ? $clog2(MICE) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // item input
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_mode,
   input  wire logic [3:0]        req_mouse_index,
   input  wire logic signed [11:0] req_delta_x,
   input  wire logic signed [11:0] req_delta_y,
   input  wire logic [2:0]        req_button_state,
   input  wire logic [2:0]        req_clear_mask,
   input  wire logic [2:0]        req_toggle_mask,
   // result output
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic [7:0]             rsp_header_byte,
   output logic signed [7:0]      rsp_report_x,
   output logic signed [7:0]      rsp_report_y,
   output logic [2:0]             rsp_buttons_now,
   output logic                   rsp_ready_now,
   output logic                   rsp_changed,
   // configuration
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   localparam logic [6:0] MICE_L = 7'(MICE);

   logic state_ff, state_in;
   logic accept;

   // latched item
   logic [2:0]         mode_ff;
   logic [3:0]         index_ff;
   logic signed [11:0] dx_ff, dy_ff;
   logic [2:0]         btn_ff, clr_ff, tog_ff;

   logic [2:0]  init_buttons_ff;
   logic [MICE-1:0] valid_ff;

   logic [AW-1:0]        req_addr, addr_ff;
   logic [ENTRY_W-1:0]   ram_q;
   logic                 ram_we;
   entry_type            cur, nxt;
   logic                 in_range;

   // result registers
   logic               rsp_valid_ff;
   logic               status_in, status_ff;
   logic [7:0]         header_in, header_ff;
   logic signed [7:0]  rx_in, rx_ff, ry_in, ry_ff;
   logic               changed_in, changed_ff;
   logic [2:0]         btn_now_in, btn_now_ff;
   logic               rdy_now_in, rdy_now_ff;

   // event arithmetic
   logic [2:0]         new_btn;
   logic signed [11:0] ev_dx, ev_dy;
   logic signed [13:0] sum_x, sum_y;
   logic signed [12:0] sat_x, sat_y;
   logic signed [12:0] rep_x, rep_y;
   logic signed [12:0] rem_x, rem_y;
   logic               ev_change;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_EXEC);
   assign req_addr = AW'(req_mouse_index);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_EXEC);
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         index_ff <= req_mouse_index;
         addr_ff  <= req_addr;
         dx_ff    <= req_delta_x;
         dy_ff    <= req_delta_y;
         btn_ff   <= req_button_state;
         clr_ff   <= req_clear_mask;
         tog_ff   <= req_toggle_mask;
      end
   end

   mmacc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MICE)
   ) u_entry_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(addr_ff),
      .wdata(nxt),
      .re(accept),
      .raddr(req_addr),
      .rdata(ram_q)
   );

   // an entry never written since reset reads as the reset entry
   assign in_range = ({3'b000, index_ff} < MICE_L);
   assign cur = (in_range && valid_ff[addr_ff]) ? entry_type'(ram_q) : ENTRY_RESET;

   // event path: button update and saturating accumulate
   always_comb begin
      ev_dx = dx_ff;
      ev_dy = dy_ff;
      case (mode_ff)
         MODE_MOVE_ABS:  new_btn = btn_ff;
         MODE_MOVE_KEEP: new_btn = cur.buttons;
         default: begin
            new_btn = (cur.buttons & ~clr_ff) ^ tog_ff;
            ev_dx = 12'sd0;
            ev_dy = 12'sd0;
         end
      endcase
      ev_change = (ev_dx != 12'sd0) || (ev_dy != 12'sd0) || (new_btn != cur.buttons);
      sum_x = 14'(cur.accum_x) + 14'(ev_dx);
      sum_y = 14'(cur.accum_y) + 14'(ev_dy);
      if (sum_x > ACC_MAX)      sat_x = 13'(ACC_MAX);
      else if (sum_x < ACC_MIN) sat_x = 13'(ACC_MIN);
      else                      sat_x = sum_x[12:0];
      if (sum_y > ACC_MAX)      sat_y = 13'(ACC_MAX);
      else if (sum_y < ACC_MIN) sat_y = 13'(ACC_MIN);
      else                      sat_y = sum_y[12:0];
   end

   // read path: clamp to report range and take off what is reported
   always_comb begin
      if (cur.accum_x > REP_MAX)      rep_x = REP_MAX;
      else if (cur.accum_x < REP_MIN) rep_x = REP_MIN;
      else                            rep_x = cur.accum_x;
      if (cur.accum_y > REP_MAX)      rep_y = REP_MAX;
      else if (cur.accum_y < REP_MIN) rep_y = REP_MIN;
      else                            rep_y = cur.accum_y;
      rem_x = cur.accum_x - rep_x;
      rem_y = cur.accum_y - rep_y;
   end

   // entry update and result
   always_comb begin
      nxt        = cur;
      status_in  = STATUS_OK;
      header_in  = 8'h00;
      rx_in      = 8'sd0;
      ry_in      = 8'sd0;
      changed_in = 1'b0;
      unique case (mode_ff) inside
         MODE_MOVE_ABS, MODE_MOVE_KEEP, MODE_BTN_EDIT: begin
            if (ev_change) begin
               nxt.buttons = new_btn;
               nxt.accum_x = sat_x;
               nxt.accum_y = sat_y;
               nxt.ready   = 1'b1;
               changed_in  = 1'b1;
            end
         end
         MODE_READ: begin
            if (!cur.ready) begin
               status_in = STATUS_NO_DATA;
            end else begin
               rx_in       = rep_x[7:0];
               ry_in       = rep_y[7:0];
               header_in   = {5'b00000, cur.buttons} | HDR_MARK;
               nxt.accum_x = rem_x;
               nxt.accum_y = rem_y;
               nxt.ready   = (rem_x != 13'sd0) || (rem_y != 13'sd0);
            end
         end
         MODE_OPEN: begin
            nxt.accum_x = 13'sd0;
            nxt.accum_y = 13'sd0;
            nxt.ready   = 1'b0;
            nxt.buttons = init_buttons_ff;
         end
         default: ;
      endcase
      btn_now_in = nxt.buttons;
      rdy_now_in = nxt.ready;
      // entry that does not exist: all zero, read still reports no data
      if (!in_range) begin
         status_in  = (mode_ff == MODE_READ) ? STATUS_NO_DATA : STATUS_OK;
         header_in  = 8'h00;
         rx_in      = 8'sd0;
         ry_in      = 8'sd0;
         changed_in = 1'b0;
         btn_now_in = 3'd0;
         rdy_now_in = 1'b0;
      end
   end

   assign ram_we = (state_ff == ST_EXEC) && in_range;

   // per-entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         status_ff  <= status_in;
         header_ff  <= header_in;
         rx_ff      <= rx_in;
         ry_ff      <= ry_in;
         changed_ff <= changed_in;
         btn_now_ff <= btn_now_in;
         rdy_now_ff <= rdy_now_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_header_byte = header_ff;
   assign rsp_report_x    = rx_ff;
   assign rsp_report_y    = ry_ff;
   assign rsp_buttons_now = btn_now_ff;
   assign rsp_ready_now   = rdy_now_ff;
   assign rsp_changed     = changed_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         init_buttons_ff <= BTN_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_INIT_BUTTONS)) begin
         init_buttons_ff <= pwdata[2:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_INIT_BUTTONS) ? {29'd0, init_buttons_ff} : 32'd0;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy) else $error("no result after execute cycle");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while still executing");

   a_changed_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_ready_now)
      else $error("changed event left entry not ready");

   a_header_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_header_byte != 8'h00) |-> rsp_header_byte[7] &&
      (rsp_status == STATUS_OK) && !rsp_changed)
      else $error("malformed report header");

endmodule

`default_nettype wire
